/* rtl/assert_macros.svh */
// Assertion macros shared by the ranger RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UER_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UER_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UER_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define UER_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/uer_pkg.sv */
// Types and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int LINE_W       = 4;
  localparam int SENSOR_W     = 2;
  localparam int COUNT_W      = 24;
  localparam int DIST_W       = 24;
  localparam int SCALE_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = COUNT_W + SCALE_W;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 3'd6;

  typedef struct packed {
    logic [15:0]         trig_low_ticks;
    logic [15:0]         trig_high_ticks;
    logic [COUNT_W-1:0]  echo_limit;
    logic [15:0]         retry_gap_ticks;
    logic [7:0]          max_retries;
    logic [SCALE_W-1:0]  scale_q16;
    logic [DIST_W-1:0]   fallback_distance;
  } cfg_t;

  // One tick's outcome from the controller, before scaling.
  typedef struct packed {
    logic [LINE_W-1:0]  trig;
    logic               busy;
    logic               done;
    logic               status;
    logic [COUNT_W-1:0] width;
  } ctrl_res_t;

endpackage

/* rtl/uer_ifs.sv */
// Handshake channels of the ultrasonic echo ranger.
interface uer_tick_if;
  logic                            valid;
  logic                            ready;
  logic                            start_req;
  logic [uer_pkg::SENSOR_W-1:0]    sensor;
  logic [uer_pkg::LINE_W-1:0]      echo_lines;
  modport source(output valid, start_req, sensor, echo_lines, input ready);
  modport sink(input valid, start_req, sensor, echo_lines, output ready);
endinterface

interface uer_res_if;
  logic                          valid;
  logic                          ready;
  logic [uer_pkg::LINE_W-1:0]    trig_lines;
  logic                          busy_res;
  logic                          done_res;
  logic [uer_pkg::DIST_W-1:0]    distance_q8;
  logic                          status;
  modport source(output valid, trig_lines, busy_res, done_res, distance_q8, status,
                 input ready);
  modport sink(input valid, trig_lines, busy_res, done_res, distance_q8, status,
               output ready);
endinterface

interface uer_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [uer_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/uer_ctrl.sv */
// Ranging sequencer: trigger, echo rise and fall waits, retries and fallback.
`include "assert_macros.svh"
module uer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  uer_pkg::cfg_t       cfg,
  uer_tick_if.sink            tick,
  output logic                s1_valid,
  input  logic                s1_ready,
  output uer_pkg::ctrl_res_t  s1
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_RISE = 3'd3;
  localparam logic [2:0] PH_FALL = 3'd4;
  localparam logic [2:0] PH_GAP  = 3'd5;

  logic [2:0]                       phase, phase_next;
  logic [uer_pkg::COUNT_W-1:0]      tick_count, tick_count_next, tick_inc;
  logic [7:0]                       failed_attempts, failed_next, failed_inc;
  logic [uer_pkg::SENSOR_W-1:0]     chosen_sensor, chosen_next;
  logic                             adv, accept, level, exhausted;
  logic [2:0]                       low_entry;
  uer_pkg::ctrl_res_t               res_next;

  assign adv        = !s1_valid || s1_ready;
  assign tick.ready = adv;
  assign accept     = tick.valid && adv;

  assign level = (int'(chosen_sensor) < uer_pkg::SENSOR_COUNT)
                 && tick.echo_lines[chosen_sensor];
  assign tick_inc   = tick_count + uer_pkg::COUNT_W'(1);
  assign failed_inc = (failed_attempts == 8'hFF) ? failed_attempts : failed_attempts + 8'd1;
  assign exhausted  = failed_inc >= cfg.max_retries;
  assign low_entry  = (cfg.trig_low_ticks == 16'd0) ? PH_HIGH : PH_LOW;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    failed_next     = failed_attempts;
    chosen_next     = chosen_sensor;
    res_next.done   = 1'b0;
    res_next.status = 1'b0;
    res_next.width  = tick_count;
    unique case (phase)
      PH_IDLE: begin
        if (tick.start_req) begin
          chosen_next     = tick.sensor;
          failed_next     = 8'd0;
          tick_count_next = '0;
          if (cfg.max_retries == 8'd0) begin
            res_next.done   = 1'b1;
            res_next.status = 1'b1;
          end else begin
            phase_next = low_entry;
          end
        end
      end
      PH_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.trig_low_ticks}) begin
          phase_next      = PH_HIGH;
          tick_count_next = '0;
        end
      end
      PH_HIGH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.trig_high_ticks}) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end
      end
      PH_RISE, PH_FALL: begin
        if (level == (phase == PH_RISE)) begin
          if (phase == PH_RISE) begin
            // echo has risen: start timing the pulse
            phase_next      = PH_FALL;
            tick_count_next = uer_pkg::COUNT_W'(1);
          end else begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            res_next.done   = 1'b1;
          end
        end else if (tick_count >= cfg.echo_limit) begin
          tick_count_next = '0;
          if (cfg.retry_gap_ticks == 16'd0) begin
            // no gap: count the failure now
            failed_next = failed_inc;
            if (exhausted) begin
              phase_next      = PH_IDLE;
              res_next.done   = 1'b1;
              res_next.status = 1'b1;
            end else begin
              phase_next = low_entry;
            end
          end else begin
            phase_next = PH_GAP;
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_GAP: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.retry_gap_ticks}) begin
          failed_next     = failed_inc;
          tick_count_next = '0;
          if (exhausted) begin
            phase_next      = PH_IDLE;
            res_next.done   = 1'b1;
            res_next.status = 1'b1;
          end else begin
            phase_next = low_entry;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    res_next.busy = phase_next != PH_IDLE;
    res_next.trig = (phase_next == PH_HIGH && int'(chosen_next) < uer_pkg::SENSOR_COUNT)
                    ? uer_pkg::LINE_W'(1) << chosen_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      failed_attempts <= '0;
      chosen_sensor   <= '0;
      s1_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        tick_count      <= tick_count_next;
        failed_attempts <= failed_next;
        chosen_sensor   <= chosen_next;
      end
      if (adv) begin
        s1_valid <= tick.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res_next;
    end
  end

  `UER_ASSERT_IMPL(a_done_not_busy, clk, rst, s1_valid && s1.done, !s1.busy)
  `UER_ASSERT_IMPL(a_trig_onehot, clk, rst, s1_valid, $onehot0(s1.trig))
  `UER_ASSERT_IMPL(a_idle_count_clear, clk, rst, phase == PH_IDLE, tick_count == '0)

endmodule

/* rtl/uer_scale.sv */
// Echo width to Q8 distance: multiply, saturate and drive the result channel.
`include "assert_macros.svh"
module uer_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uer_pkg::SCALE_W-1:0]   scale_q16,
  input  logic [uer_pkg::DIST_W-1:0]    fallback_distance,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  uer_pkg::ctrl_res_t            s1,
  uer_res_if.source                     res
);

  logic                          v2, v3, r2, r3;
  logic [uer_pkg::LINE_W-1:0]    trig2;
  logic                          busy2, done2, status2;
  logic [uer_pkg::PROD_W-1:0]    prod2;
  logic [uer_pkg::DIST_W-1:0]    sat_dist, dist_next;

  assign r3       = !v3 || res.ready;
  assign r2       = !v2 || r3;
  assign s1_ready = r2;

  // clamp anything above the 24-bit range
  assign sat_dist = (|prod2[uer_pkg::PROD_W-1:uer_pkg::FRAC_W+uer_pkg::DIST_W])
                    ? '1 : prod2[uer_pkg::FRAC_W+uer_pkg::DIST_W-1:uer_pkg::FRAC_W];
  assign dist_next = !done2 ? '0 : (status2 ? fallback_distance : sat_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= s1_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && s1_valid) begin
      trig2   <= s1.trig;
      busy2   <= s1.busy;
      done2   <= s1.done;
      status2 <= s1.status;
      prod2   <= uer_pkg::PROD_W'(s1.width) * uer_pkg::PROD_W'(scale_q16);
    end
    if (r3 && v2) begin
      res.trig_lines  <= trig2;
      res.busy_res    <= busy2;
      res.done_res    <= done2;
      res.status      <= done2 && status2;
      res.distance_q8 <= dist_next;
    end
  end

  assign res.valid = v3;

  `UER_ASSERT_IMPL(a_quiet_when_not_done, clk, rst, v3 && !res.done_res, res.distance_q8 == '0 && !res.status)
  `UER_ASSERT_IMPL(a_done_is_idle, clk, rst, v3 && res.done_res, !res.busy_res && res.trig_lines == '0)
  `UER_ASSERT_NEXT(a_stage_advance, clk, rst, v2 && r3, v3)

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: one input word is one timer tick carrying a start request, a sensor
// number and the four sampled echo lines; every accepted tick yields exactly one result word
// with the trigger levels, busy, done, distance and status after that tick. A tick is taken
// every clock cycle unless a stalled result holds the input; its result word passes the
// sequencer register, the 24x32 width-times-scale multiplier register and the result
// register before it is presented on res. A stalled result holds those registers and, once
// they are full, the tick input.
// Registers are written through the cfg channel (always ready) at indexes 0..6: trigger low
// ticks, trigger high ticks, timeout, retry gap, max retries, Q16 scale, fallback distance;
// other indexes are ignored. Write them only while no measurement or result is in flight.
module ultrasonic_echo_ranger (
  input  logic       clk,
  input  logic       rst,
  uer_tick_if.sink   tick,
  uer_res_if.source  res,
  uer_cfg_if.sink    cfg
);

  uer_pkg::cfg_t       regs;
  uer_pkg::ctrl_res_t  s1;
  logic                s1_valid, s1_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trig_low_ticks    <= 16'd80;
      regs.trig_high_ticks   <= 16'd400;
      regs.echo_limit        <= 24'd1000000;
      regs.retry_gap_ticks   <= 16'd4000;
      regs.max_retries       <= 8'd3;
      regs.scale_q16         <= 32'd0;
      regs.fallback_distance <= 24'd25600;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        uer_pkg::CFG_TRIG_LOW:    regs.trig_low_ticks    <= cfg.data[15:0];
        uer_pkg::CFG_TRIG_HIGH:   regs.trig_high_ticks   <= cfg.data[15:0];
        uer_pkg::CFG_TIMEOUT:     regs.echo_limit        <= cfg.data[23:0];
        uer_pkg::CFG_RETRY_GAP:   regs.retry_gap_ticks   <= cfg.data[15:0];
        uer_pkg::CFG_MAX_RETRIES: regs.max_retries       <= cfg.data[7:0];
        uer_pkg::CFG_SCALE:       regs.scale_q16         <= cfg.data;
        uer_pkg::CFG_FALLBACK:    regs.fallback_distance <= cfg.data[23:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  uer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .tick     (tick),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  uer_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .scale_q16         (regs.scale_q16),
    .fallback_distance (regs.fallback_distance),
    .s1_valid          (s1_valid),
    .s1_ready          (s1_ready),
    .s1                (s1),
    .res               (res)
  );

endmodule
